FILE: rtl/malu_pkg.sv
`timescale 1ns / 1ps
package malu_pkg;
  localparam logic [3:0] LINE_OR  = 4'h8;
  localparam logic [3:0] LINE_SUB = 4'h9;
  localparam logic [3:0] LINE_CMP = 4'hB;
  localparam logic [1:0] TRAP_NONE  = 2'd0;
  localparam logic [1:0] TRAP_DIV0  = 2'd1;
  localparam logic [1:0] TRAP_UNIMP = 2'd2;
  localparam int DivSteps = 32;
  localparam int DivStages = 8;
  localparam int DivStepsPerStage = DivSteps / DivStages;

  typedef struct packed {
    logic [31:0] result;
    logic        write_result;
    logic        result_to_ea;
    logic [4:0]  ccr_out;
    logic [1:0]  trap_code;
  } res_t;

  // divide job carried through the pipeline
  typedef struct packed {
    logic        active;
    logic        signed_div;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [15:0] dvs;
    logic [4:0]  ccr;
  } div_t;
endpackage

FILE: rtl/malu_if.sv
`timescale 1ns / 1ps
interface malu_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode;
  logic [31:0] ea_value;
  logic [31:0] reg_value;
  logic [4:0]  ccr_in;
  modport source (output valid, opcode, ea_value, reg_value, ccr_in, input ready);
  modport sink (input valid, opcode, ea_value, reg_value, ccr_in, output ready);
endinterface

interface malu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        write_result;
  logic        result_to_ea;
  logic [4:0]  ccr_out;
  logic [1:0]  trap_code;
  modport source (output valid, result, write_result, result_to_ea, ccr_out, trap_code,
                  input ready);
  modport sink (input valid, result, write_result, result_to_ea, ccr_out, trap_code,
                output ready);
endinterface

FILE: rtl/m68k_alu_group_8_9_b.sv
`timescale 1ns / 1ps
// ALU execute unit for 68000 lines 8, 9 and B (OR, DIV, SUB, SUBX, SUBA,
// CMP, CMPA, CMPM, EOR).
// in:  opcode word with fetched ea_value, reg_value and ccr_in.
// out: result, write_result, result_to_ea, ccr_out, trap_code.
// One word is accepted every cycle while the output is not stalled. The
// path is a decode register, then DivStages = 8 divider stages of four
// restoring steps each; the last divider stage also does the sign and
// overflow fix-up and holds the output. Non-divide words ride along the
// same pipe so order is kept.
// A stall on the output freezes the whole pipe; ready to the source is
// the output ready or a free output register, so nothing is lost.
// Reset clears all valid bits; payload registers are not reset.
module m68k_alu_group_8_9_b import malu_pkg::*; (
  input logic     clk,
  input logic     rst,
  malu_in_if.sink   in_ch,
  malu_out_if.source out_ch
);
  res_t res_d;
  div_t div_d;
  logic adv;
  logic [DivStages:0] vld;
  res_t res_p [DivStages+1];
  div_t div_p [DivStages];
  div_t div_c [DivStages];
  res_t fin;
  logic [15:0] q16, r16;
  logic ovf;
  div_t dl;

  malu_decode u_dec (
    .opcode(in_ch.opcode), .ea_value(in_ch.ea_value), .reg_value(in_ch.reg_value),
    .ccr_in(in_ch.ccr_in), .res(res_d), .div(div_d)
  );

  assign adv = out_ch.ready | ~vld[DivStages];
  assign in_ch.ready = adv;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    malu_div_stage #(.Steps(DivStepsPerStage)) u_st (.din(div_p[g]), .dout(div_c[g]));
  end

  always_comb begin
    dl = div_c[DivStages-1];
    q16 = dl.neg_q ? -dl.quo[15:0] : dl.quo[15:0];
    r16 = dl.neg_r ? -dl.rem[15:0] : dl.rem[15:0];
    if (dl.signed_div)
      ovf = dl.neg_q ? (dl.quo > 32'h8000) : (dl.quo > 32'h7FFF);
    else
      ovf = dl.quo > 32'hFFFF;
    fin = res_p[DivStages-1];
    if (dl.active) begin
      if (ovf) begin
        fin.ccr_out = {dl.ccr[4:2], 2'b10};
      end else begin
        fin.result = {r16, q16};
        fin.write_result = 1'b1;
        fin.ccr_out = {dl.ccr[4], q16[15], q16 == 16'd0, 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DivStages-1:0], in_ch.valid};
    end
    if (adv) begin
      res_p[0] <= res_d;
      div_p[0] <= div_d;
      for (int i = 1; i < DivStages; i++) begin
        res_p[i] <= res_p[i-1];
        div_p[i] <= div_c[i-1];
      end
      res_p[DivStages] <= fin;
    end
  end

  assign out_ch.valid        = vld[DivStages];
  assign out_ch.result       = res_p[DivStages].result;
  assign out_ch.write_result = res_p[DivStages].write_result;
  assign out_ch.result_to_ea = res_p[DivStages].result_to_ea;
  assign out_ch.ccr_out      = res_p[DivStages].ccr_out;
  assign out_ch.trap_code    = res_p[DivStages].trap_code;
endmodule

FILE: rtl/malu_decode.sv
`timescale 1ns / 1ps
module malu_decode import malu_pkg::*; (
  input  logic [15:0] opcode,
  input  logic [31:0] ea_value,
  input  logic [31:0] reg_value,
  input  logic [4:0]  ccr_in,
  output res_t        res,
  output div_t        div
);
  logic [3:0]  line;
  logic        dir;
  logic [1:0]  sz;
  logic [2:0]  mode;
  logic [31:0] m, sg, sa, d, s, sext, diff, fres;
  logic [32:0] wide;
  logic        bin, c, v, n, z;
  logic [31:0] dvd_abs;
  logic [15:0] dvs_abs;

  always_comb begin
    line = opcode[15:12];
    dir  = opcode[8];
    sz   = opcode[7:6];
    mode = opcode[5:3];
    m  = (sz == 2'd0) ? 32'hFF : (sz == 2'd1) ? 32'hFFFF : 32'hFFFF_FFFF;
    sg = (sz == 2'd0) ? 32'h80 : (sz == 2'd1) ? 32'h8000 : 32'h8000_0000;
    sext = {{16{ea_value[15]}}, ea_value[15:0]};
    sa = dir ? ea_value : sext;
    bin = 1'b0;
    if (sz == 2'd3) begin
      d = reg_value; s = sa; m = 32'hFFFF_FFFF; sg = 32'h8000_0000;
    end else if (line == LINE_SUB && dir && mode[2:1] == 2'b00) begin
      d = reg_value; s = ea_value; bin = ccr_in[4];
    end else if (line == LINE_SUB && dir) begin
      d = ea_value; s = reg_value;
    end else begin
      d = reg_value; s = ea_value;
    end
    wide = {1'b0, s & m} + {32'd0, bin};
    diff = ((d & m) - wide[31:0]) & m;
    c = wide > {1'b0, d & m};
    v = |(((d & m) ^ (s & m)) & ((d & m) ^ diff) & sg);
    n = |(diff & sg);
    z = diff == 32'd0;
    fres = ((line == LINE_OR) ? (ea_value | reg_value) : (ea_value ^ reg_value)) & m;

    res = '0;
    res.ccr_out = ccr_in;
    div = '0;
    div.ccr = ccr_in;
    dvd_abs = (dir && reg_value[31]) ? -reg_value : reg_value;
    dvs_abs = (dir && ea_value[15]) ? -ea_value[15:0] : ea_value[15:0];
    case (line)
      LINE_OR: begin
        if (sz == 2'd3) begin
          if (ea_value[15:0] == 16'd0) begin
            res.trap_code = TRAP_DIV0;
            res.ccr_out[0] = 1'b0;
          end else begin
            div.active = 1'b1;
            div.signed_div = dir;
            div.neg_q = dir & (reg_value[31] ^ ea_value[15]);
            div.neg_r = dir & reg_value[31];
            div.quo = dvd_abs;
            div.dvs = dvs_abs;
          end
        end else if (dir && mode[2:1] == 2'b00) begin
          res.trap_code = TRAP_UNIMP;
        end else begin
          res.result = fres;
          res.write_result = 1'b1;
          res.result_to_ea = dir;
          res.ccr_out = {ccr_in[4], |(fres & sg), fres == 32'd0, 2'b00};
        end
      end
      LINE_SUB: begin
        if (sz == 2'd3) begin
          res.result = reg_value - sa;
          res.write_result = 1'b1;
        end else if (dir && mode[2:1] == 2'b00) begin
          res.result = diff;
          res.write_result = 1'b1;
          res.result_to_ea = mode[0];
          res.ccr_out = {c, n, z & ccr_in[2], v, c};
        end else begin
          res.result = diff;
          res.write_result = 1'b1;
          res.result_to_ea = dir;
          res.ccr_out = {c, n, z, v, c};
        end
      end
      LINE_CMP: begin
        if (sz != 2'd3 && dir && mode != 3'd1) begin
          res.result = fres;
          res.write_result = 1'b1;
          res.result_to_ea = 1'b1;
          res.ccr_out = {ccr_in[4], |(fres & sg), fres == 32'd0, 2'b00};
        end else begin
          res.ccr_out = {ccr_in[4], n, z, v, c};
        end
      end
      default: res.trap_code = TRAP_UNIMP;
    endcase
  end
endmodule

FILE: rtl/malu_div_stage.sv
`timescale 1ns / 1ps
// Several restoring steps per stage on magnitudes.
module malu_div_stage import malu_pkg::*; #(
  parameter int Steps = 4
) (
  input  div_t din,
  output div_t dout
);
  logic [32:0] trial;
  logic [31:0] r, q;
  always_comb begin
    dout = din;
    r = din.rem;
    q = din.quo;
    trial = '0;
    for (int i = 0; i < Steps; i++) begin
      trial = {r, q[31]} - {17'd0, din.dvs};
      if (!trial[32]) begin
        r = trial[31:0];
      end else begin
        r = {r[30:0], q[31]};
      end
      q = {q[30:0], ~trial[32]};
    end
    dout.rem = r;
    dout.quo = q;
  end
endmodule
